### rtl/esc_temp_pkg.sv
// shared types, constants and lookup tables for the telemetry frame temperature block
// no dependencies; used by esc_temp_ctrl, esc_temp_dp and the top level
`default_nettype none

package esc_temp_pkg;

   localparam int DEF_FRAME_BYTES = 24;

   localparam logic [7:0] SYNC_BYTE = 8'h9b;
   localparam logic [7:0] HDR1_BYTE = 8'h16;
   localparam logic [7:0] HDR2_BYTE = 8'h01;
   localparam logic [7:0] READ_MIN  = 8'd33;
   localparam logic [7:0] READ_MAX  = 8'd241;

   localparam int READ_A_POS = 18;
   localparam int READ_B_POS = 19;

   localparam int TABLE_LEN    = 119;
   localparam int IDX_W        = $clog2(TABLE_LEN);
   localparam int SEARCH_STEPS = IDX_W;
   localparam int STEP_W       = $clog2(SEARCH_STEPS);

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_BAD_HDR = 3'd1,
      ST_BAD_SUM = 3'd2,
      ST_HIGH    = 3'd3,
      ST_LOW     = 3'd4
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic accept;   // take the byte on req_tdata
      logic check;    // judge the finished frame
      logic step;     // one binary search step
      logic load;     // move the result into the output register
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic frame_done;   // the offered byte completes a frame
      logic pass;         // header, checksum and range all good
      logic search_last;  // final search step
      logic out_free;     // output register can take a result
   } dp_sts_type;

   // descending adc readings
   localparam logic [7:0] ROM_ADC [0:TABLE_LEN-1] = '{
      8'd241, 8'd240, 8'd239, 8'd238, 8'd237, 8'd236, 8'd235, 8'd234, 8'd233, 8'd232,
      8'd231, 8'd230, 8'd229, 8'd228, 8'd227, 8'd226, 8'd224, 8'd223, 8'd222, 8'd220,
      8'd219, 8'd217, 8'd216, 8'd214, 8'd213, 8'd211, 8'd209, 8'd208, 8'd206, 8'd204,
      8'd202, 8'd201, 8'd199, 8'd197, 8'd195, 8'd193, 8'd191, 8'd189, 8'd187, 8'd185,
      8'd183, 8'd181, 8'd179, 8'd177, 8'd174, 8'd172, 8'd170, 8'd168, 8'd166, 8'd164,
      8'd161, 8'd159, 8'd157, 8'd154, 8'd152, 8'd150, 8'd148, 8'd146, 8'd143, 8'd141,
      8'd139, 8'd136, 8'd134, 8'd132, 8'd130, 8'd128, 8'd125, 8'd123, 8'd121, 8'd119,
      8'd117, 8'd115, 8'd113, 8'd111, 8'd109, 8'd106, 8'd105, 8'd103, 8'd101, 8'd99,
      8'd97,  8'd95,  8'd93,  8'd91,  8'd90,  8'd88,  8'd85,  8'd84,  8'd82,  8'd81,
      8'd79,  8'd77,  8'd76,  8'd74,  8'd73,  8'd72,  8'd69,  8'd68,  8'd66,  8'd65,
      8'd64,  8'd62,  8'd61,  8'd59,  8'd58,  8'd56,  8'd54,  8'd53,  8'd51,  8'd50,
      8'd48,  8'd46,  8'd44,  8'd43,  8'd41,  8'd39,  8'd37,  8'd35,  8'd33
   };

   // temperature in degrees for each adc entry
   localparam logic [7:0] ROM_DEG [0:TABLE_LEN-1] = '{
      8'd0,   8'd1,   8'd2,   8'd3,   8'd4,   8'd5,   8'd6,   8'd7,   8'd8,   8'd9,
      8'd10,  8'd11,  8'd12,  8'd13,  8'd14,  8'd15,  8'd16,  8'd17,  8'd18,  8'd19,
      8'd20,  8'd21,  8'd22,  8'd23,  8'd24,  8'd25,  8'd26,  8'd27,  8'd28,  8'd29,
      8'd30,  8'd31,  8'd32,  8'd33,  8'd34,  8'd35,  8'd36,  8'd37,  8'd38,  8'd39,
      8'd40,  8'd41,  8'd42,  8'd43,  8'd44,  8'd45,  8'd46,  8'd47,  8'd48,  8'd49,
      8'd50,  8'd51,  8'd52,  8'd53,  8'd54,  8'd55,  8'd56,  8'd57,  8'd58,  8'd59,
      8'd60,  8'd61,  8'd62,  8'd63,  8'd64,  8'd65,  8'd66,  8'd67,  8'd68,  8'd69,
      8'd70,  8'd71,  8'd72,  8'd73,  8'd74,  8'd75,  8'd76,  8'd77,  8'd78,  8'd79,
      8'd80,  8'd81,  8'd82,  8'd83,  8'd84,  8'd85,  8'd86,  8'd87,  8'd88,  8'd89,
      8'd90,  8'd91,  8'd92,  8'd93,  8'd94,  8'd95,  8'd96,  8'd97,  8'd98,  8'd99,
      8'd100, 8'd102, 8'd103, 8'd104, 8'd105, 8'd106, 8'd108, 8'd109, 8'd111, 8'd112,
      8'd114, 8'd116, 8'd117, 8'd119, 8'd121, 8'd124, 8'd126, 8'd128, 8'd129
   };

endpackage

`default_nettype wire

### rtl/esc_temp_ctrl.sv
// control state machine: receive, check, table search, hand off result
// depends on esc_temp_pkg
`default_nettype none

module esc_temp_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_tvalid,
   output logic                     req_tready,
   input  esc_temp_pkg::dp_sts_type sts,
   output esc_temp_pkg::dp_cmd_type cmd
);

   typedef enum logic [3:0] {
      S_RECV   = 4'b0001,
      S_CHECK  = 4'b0010,
      S_SEARCH = 4'b0100,
      S_EMIT   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         S_RECV: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
            if (req_tvalid && sts.frame_done) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = sts.pass ? S_SEARCH : S_EMIT;
         end
         S_SEARCH: begin
            cmd.step = 1'b1;
            if (sts.search_last) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.load = 1'b1;
               state_in = S_RECV;
            end
         end
         default: begin
            state_in = S_RECV;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_RECV;
      end else begin
         state_ff <= state_in;
      end
   end

   // a finished search always ends in the hand-off state
   a_search_to_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH && sts.search_last) |=> (state_ff == S_EMIT))
      else $error("search did not hand off");

endmodule

`default_nettype wire

### rtl/esc_temp_dp.sv
// datapath: running frame sums and header flags, binary table search, output register
// depends on esc_temp_pkg
`default_nettype none

module esc_temp_dp #(
   parameter int FRAME_BYTES = esc_temp_pkg::DEF_FRAME_BYTES
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire  [esc_temp_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire                                    rsp_tready,
   output logic                                   rsp_tvalid,
   output logic [esc_temp_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  esc_temp_pkg::dp_cmd_type               cmd,
   output esc_temp_pkg::dp_sts_type               sts
);

   localparam int POS_W = $clog2(FRAME_BYTES);
   localparam int IDX_W = esc_temp_pkg::IDX_W;

   logic [POS_W-1:0]              pos_ff, pos_in;
   logic [15:0]                   sum_ff, sum_in;
   logic [15:0]                   word_ff, word_in;
   logic                          hdr_ok_ff, hdr_ok_in;
   logic [7:0]                    read_a_ff, read_a_in;
   logic [7:0]                    read_b_ff, read_b_in;
   logic [7:0]                    reading_ff;
   esc_temp_pkg::status_type      status_ff, status_in;
   logic [IDX_W-1:0]              lo_ff, lo_in;
   logic [IDX_W-1:0]              hi_ff, hi_in;
   logic [esc_temp_pkg::STEP_W-1:0] step_ff;
   logic                          rsp_valid_ff;
   logic [2:0]                    rsp_status_ff;
   logic [7:0]                    rsp_temp_ff;

   logic [7:0]       rx;
   logic             is_sync;
   logic [7:0]       reading;
   logic [IDX_W:0]   mid_sum;
   logic [IDX_W-1:0] mid;

   assign rx      = req_tdata;
   assign is_sync = (rx == esc_temp_pkg::SYNC_BYTE);

   // frame assembly, one byte per beat
   always_comb begin
      pos_in    = pos_ff;
      sum_in    = sum_ff;
      word_in   = word_ff;
      hdr_ok_in = hdr_ok_ff;
      read_a_in = read_a_ff;
      read_b_in = read_b_ff;
      if (cmd.accept) begin
         if (is_sync) begin
            pos_in    = POS_W'(1);
            sum_in    = {8'h00, esc_temp_pkg::SYNC_BYTE};
            hdr_ok_in = 1'b1;
         end else begin
            if (int'(pos_ff) == FRAME_BYTES - 1) begin
               pos_in = '0;
            end else begin
               pos_in = pos_ff + POS_W'(1);
            end
            if (pos_ff == '0) begin
               sum_in    = {8'h00, rx};
               hdr_ok_in = 1'b0;
            end else if (int'(pos_ff) <= FRAME_BYTES - 3) begin
               sum_in = sum_ff + {8'h00, rx};
            end
            if (int'(pos_ff) == 1) begin
               hdr_ok_in = hdr_ok_ff && (rx == esc_temp_pkg::HDR1_BYTE);
            end
            if (int'(pos_ff) == 2) begin
               hdr_ok_in = hdr_ok_ff && (rx == esc_temp_pkg::HDR2_BYTE);
            end
            if (int'(pos_ff) == FRAME_BYTES - 2) begin
               word_in[7:0] = rx;
            end
            if (int'(pos_ff) == FRAME_BYTES - 1) begin
               word_in[15:8] = rx;
            end
            if (int'(pos_ff) == esc_temp_pkg::READ_A_POS) begin
               read_a_in = rx;
            end
            if (int'(pos_ff) == esc_temp_pkg::READ_B_POS) begin
               read_b_in = rx;
            end
         end
      end
   end

   // frame judgment, priority header, checksum, range
   assign reading = (read_a_ff <= read_b_ff) ? read_a_ff : read_b_ff;

   always_comb begin
      if (!hdr_ok_ff) begin
         status_in = esc_temp_pkg::ST_BAD_HDR;
      end else if (sum_ff != word_ff) begin
         status_in = esc_temp_pkg::ST_BAD_SUM;
      end else if (reading > esc_temp_pkg::READ_MAX) begin
         status_in = esc_temp_pkg::ST_HIGH;
      end else if (reading < esc_temp_pkg::READ_MIN) begin
         status_in = esc_temp_pkg::ST_LOW;
      end else begin
         status_in = esc_temp_pkg::ST_OK;
      end
   end

   // binary search for the first descending entry at or below the reading
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[IDX_W:1];

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (cmd.check) begin
         lo_in = '0;
         hi_in = IDX_W'(esc_temp_pkg::TABLE_LEN - 1);
      end else if (cmd.step) begin
         if (esc_temp_pkg::ROM_ADC[mid] <= reading_ff) begin
            hi_in = mid;
         end else begin
            lo_in = mid + IDX_W'(1);
         end
      end
   end

   assign sts.frame_done  = !is_sync && (int'(pos_ff) == FRAME_BYTES - 1);
   assign sts.pass        = (status_in == esc_temp_pkg::ST_OK);
   assign sts.search_last = (int'(step_ff) == esc_temp_pkg::SEARCH_STEPS - 1);
   assign sts.out_free    = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         if (cmd.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff    <= sum_in;
      word_ff   <= word_in;
      hdr_ok_ff <= hdr_ok_in;
      read_a_ff <= read_a_in;
      read_b_ff <= read_b_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      if (cmd.check) begin
         status_ff  <= status_in;
         reading_ff <= reading;
         step_ff    <= '0;
      end else if (cmd.step) begin
         step_ff <= step_ff + esc_temp_pkg::STEP_W'(1);
      end
      if (cmd.load) begin
         rsp_status_ff <= status_ff;
         rsp_temp_ff   <= (status_ff == esc_temp_pkg::ST_OK) ?
                          esc_temp_pkg::ROM_DEG[lo_ff] : 8'd0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_temp_ff, rsp_status_ff};

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      int'(pos_ff) < FRAME_BYTES)
      else $error("byte position past frame end");

   a_search_order: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (lo_ff <= hi_ff))
      else $error("search bounds crossed");

endmodule

`default_nettype wire

### rtl/esc_telemetry_frame_temperature.sv
// after the last byte of a frame: a check state, then on a good frame seven binary search steps
// over the 119-entry table, then a load into the output register once it is free
// throughput: one byte per cycle while receiving; no byte is taken between frames while the
// frame is checked, searched and handed off, as req_tready is low in those states
// reset: synchronous, active high; clears the byte position, state machine and output valid
// depends on esc_temp_pkg, esc_temp_ctrl, esc_temp_dp
`default_nettype none

module esc_telemetry_frame_temperature #(
   parameter int FRAME_BYTES = esc_temp_pkg::DEF_FRAME_BYTES
) (
   input  wire                                 clock,
   input  wire                                 reset,
   // received byte stream
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [esc_temp_pkg::REQ_DATA_W-1:0] req_tdata,   // [7:0] rx_byte
   // one result beat per completed frame
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [esc_temp_pkg::RSP_DATA_W-1:0] rsp_tdata    // [2:0] status, [10:3] temperature
);

   // command and status between controller and datapath
   esc_temp_pkg::dp_cmd_type cmd;
   esc_temp_pkg::dp_sts_type sts;

   // state machine: receive bytes, judge frame, search table, hand off
   esc_temp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // running checksum and header flags, search unit, output register
   esc_temp_dp #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

   // only the five defined status codes leave the block
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[2:0] <= esc_temp_pkg::ST_LOW))
      else $error("undefined status code");

   // a failed frame carries no temperature
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[2:0] != esc_temp_pkg::ST_OK) |-> (rsp_tdata[10:3] == 8'd0))
      else $error("temperature on failed frame");

endmodule

`default_nettype wire

### tb/testbench.sv
// self-checking testbench for esc_telemetry_frame_temperature: byte stream in, one verdict per frame
// depends on esc_temp_pkg and the rtl top level; holds its own frame predictor in a scoreboard class
`timescale 1ns / 1ps

module testbench;

   localparam int FRAME_LEN   = esc_temp_pkg::DEF_FRAME_BYTES;
   localparam int BYTE_TARGET = 1150;   // random part stops once this many bytes went in
   localparam int CALM_BYTES  = 200;    // no idling on either side for the last stretch
   localparam int STALL_LIMIT = 2000;   // cycles without any handshake before giving up
   localparam int DRAIN_WAIT  = 30;     // covers the judge and search after the last frame

   typedef enum {FR_GOOD, FR_BAD_HDR, FR_BAD_SUM} frame_kind_type;

   logic                                clock;
   logic                                reset;
   logic                                req_tvalid;
   logic                                req_tready;
   logic [esc_temp_pkg::REQ_DATA_W-1:0] req_tdata;    // [7:0] rx_byte
   logic                                rsp_tvalid;
   logic                                rsp_tready;
   logic [esc_temp_pkg::RSP_DATA_W-1:0] rsp_tdata;    // [2:0] status, [10:3] temperature

   bit          calm_tail;
   int unsigned bytes_sent;
   int unsigned idle_cycles;

   esc_telemetry_frame_temperature #(
      .FRAME_BYTES(FRAME_LEN)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   // frame predictor plus the queue of verdicts still owed by the block
   class frame_scoreboard;
      typedef struct {
         esc_temp_pkg::status_type status;
         logic [7:0]               degrees;
      } verdict_type;

      verdict_type awaited[$];
      logic [7:0]  frame_bytes [FRAME_LEN];
      int unsigned position;
      int unsigned errors;
      int unsigned frames_judged;
      int unsigned status_seen [5];

      function new();
         position = 0;
         errors = 0;
         frames_judged = 0;
         foreach (frame_bytes[i]) frame_bytes[i] = '0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      // judge the assembled frame: header, then checksum, then reading range
      function verdict_type judge_frame();
         verdict_type v;
         logic [15:0] sum;
         logic [15:0] word;
         logic [7:0]  reading;
         v.status = esc_temp_pkg::ST_OK;
         v.degrees = '0;
         if (frame_bytes[0] != esc_temp_pkg::SYNC_BYTE ||
             frame_bytes[1] != esc_temp_pkg::HDR1_BYTE ||
             frame_bytes[2] != esc_temp_pkg::HDR2_BYTE) begin
            v.status = esc_temp_pkg::ST_BAD_HDR;
            return v;
         end
         sum = '0;
         for (int i = 0; i < FRAME_LEN - 2; i++) sum = sum + {8'h00, frame_bytes[i]};
         word = {frame_bytes[FRAME_LEN-1], frame_bytes[FRAME_LEN-2]};
         if (word != sum) begin
            v.status = esc_temp_pkg::ST_BAD_SUM;
            return v;
         end
         reading = (frame_bytes[esc_temp_pkg::READ_A_POS] <=
                    frame_bytes[esc_temp_pkg::READ_B_POS]) ?
                   frame_bytes[esc_temp_pkg::READ_A_POS] :
                   frame_bytes[esc_temp_pkg::READ_B_POS];
         if (reading > esc_temp_pkg::READ_MAX) begin
            v.status = esc_temp_pkg::ST_HIGH;
         end else if (reading < esc_temp_pkg::READ_MIN) begin
            v.status = esc_temp_pkg::ST_LOW;
         end else begin
            // table descends, so the lowest index at or below the reading wins
            for (int i = esc_temp_pkg::TABLE_LEN - 1; i >= 0; i--)
               if (esc_temp_pkg::ROM_ADC[i] <= reading) v.degrees = esc_temp_pkg::ROM_DEG[i];
         end
         return v;
      endfunction

      function void note_byte(logic [7:0] b);
         int unsigned pos;
         pos = (position >= FRAME_LEN) ? 0 : position;
         frame_bytes[pos] = b;
         pos++;
         if (b == esc_temp_pkg::SYNC_BYTE) begin
            frame_bytes[0] = esc_temp_pkg::SYNC_BYTE;
            pos = 1;
         end
         if (pos >= FRAME_LEN) begin
            position = 0;
            awaited.push_back(judge_frame());
         end else begin
            position = pos;
         end
      endfunction

      function void check_result(logic [esc_temp_pkg::RSP_DATA_W-1:0] data);
         verdict_type              v;
         esc_temp_pkg::status_type got_status;
         logic [7:0]               got_degrees;
         got_status = esc_temp_pkg::status_type'(data[2:0]);
         got_degrees = data[10:3];
         if (awaited.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: unexpected verdict beat status %0d temperature %0d",
                        $realtime, got_status, got_degrees);
            return;
         end
         v = awaited.pop_front();
         frames_judged++;
         status_seen[v.status]++;
         if (got_status != v.status || got_degrees != v.degrees) begin
            errors++;
            if (errors <= 10)
               $display("%0t: frame %0d expected status %0d temperature %0d, got %0d / %0d",
                        $realtime, frames_judged, v.status, v.degrees, got_status, got_degrees);
         end
      endfunction
   endclass

   frame_scoreboard board = new();

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // any byte except the resync value
   function automatic logic [7:0] any_but_sync();
      logic [7:0] v;
      do v = 8'($urandom_range(0, 255)); while (v == esc_temp_pkg::SYNC_BYTE);
      return v;
   endfunction

   // adc reading, mostly inside the table range, some outside and some on exact entries
   function automatic logic [7:0] pick_reading();
      logic [7:0] v;
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55)
         v = 8'($urandom_range(esc_temp_pkg::READ_MIN, esc_temp_pkg::READ_MAX));
      else if (r < 75)
         v = esc_temp_pkg::ROM_ADC[$urandom_range(0, esc_temp_pkg::TABLE_LEN - 1)];
      else if (r < 85)
         v = 8'($urandom_range(esc_temp_pkg::READ_MAX + 8'd1, 255));
      else if (r < 95)
         v = 8'($urandom_range(0, esc_temp_pkg::READ_MIN - 8'd1));
      else begin
         case ($urandom_range(0, 3))
            0: v = esc_temp_pkg::READ_MIN;
            1: v = esc_temp_pkg::READ_MAX;
            2: v = esc_temp_pkg::READ_MIN - 8'd1;
            default: v = esc_temp_pkg::READ_MAX + 8'd1;
         endcase
      end
      // a resync value in the reading slot would restart the frame
      if (v == esc_temp_pkg::SYNC_BYTE) v = esc_temp_pkg::SYNC_BYTE - 8'd1;
      return v;
   endfunction

   // one beat on the byte side; optional idle burst ahead of it
   task automatic send_byte(input logic [7:0] b);
      if (!calm_tail && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do @(posedge clock); while (req_tready !== 1'b1);
      board.note_byte(b);
      bytes_sent++;
      @(negedge clock);
   endtask

   // build a frame and send its first count bytes
   task automatic send_frame(input frame_kind_type kind, input logic [7:0] rd_a,
                             input logic [7:0] rd_b, input int unsigned count);
      logic [7:0]  fr [FRAME_LEN];
      logic [15:0] sum;
      logic [15:0] word;
      int unsigned idx;
      bit          clean;
      fr[0] = esc_temp_pkg::SYNC_BYTE;
      fr[1] = esc_temp_pkg::HDR1_BYTE;
      fr[2] = esc_temp_pkg::HDR2_BYTE;
      for (int i = 3; i < FRAME_LEN - 2; i++) fr[i] = any_but_sync();
      fr[esc_temp_pkg::READ_A_POS] = rd_a;
      fr[esc_temp_pkg::READ_B_POS] = rd_b;
      // nudge a payload byte until neither checksum byte looks like a resync
      do begin
         sum = '0;
         for (int i = 0; i < FRAME_LEN - 2; i++) sum = sum + {8'h00, fr[i]};
         clean = (sum[7:0] != esc_temp_pkg::SYNC_BYTE) &&
                 (sum[15:8] != esc_temp_pkg::SYNC_BYTE);
         if (!clean) begin
            fr[3] = fr[3] + 8'd1;
            if (fr[3] == esc_temp_pkg::SYNC_BYTE) fr[3] = fr[3] + 8'd1;
         end
      end while (!clean);
      word = sum;
      if (kind == FR_BAD_SUM) begin
         do word = sum ^ 16'($urandom_range(1, 65535));
         while (word[7:0] == esc_temp_pkg::SYNC_BYTE || word[15:8] == esc_temp_pkg::SYNC_BYTE);
      end
      fr[FRAME_LEN-2] = word[7:0];
      fr[FRAME_LEN-1] = word[15:8];
      if (kind == FR_BAD_HDR) begin
         idx = $urandom_range(1, 2);
         begin
            logic [7:0] good;
            good = fr[idx];
            do fr[idx] = any_but_sync(); while (fr[idx] == good);
         end
      end
      for (int i = 0; i < count; i++) send_byte(fr[i]);
   endtask

   // verdict side: stall bursts, then ready stretches; steady ready at the end
   initial begin
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if (!calm_tail && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(negedge clock);
      end
   end

   // compare each accepted verdict beat
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
         board.check_result(rsp_tdata);
   end

   // watchdog: too long without any beat on either side ends the run
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("testbench: errors");
            $finish;
         end
      end
   end

   initial begin
      int unsigned pick;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      calm_tail = 1'b0;
      bytes_sent = 0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed: first frame after reset lacks the sync byte, all-zero / all-one bytes
      for (int i = 0; i < FRAME_LEN; i++) send_byte((i % 2) ? 8'hff : 8'h00);
      send_frame(FR_GOOD, 8'd33, 8'd40, FRAME_LEN);     // lowest reading in range
      send_frame(FR_GOOD, 8'd250, 8'd241, FRAME_LEN);   // highest reading in range
      send_frame(FR_GOOD, 8'd242, 8'd255, FRAME_LEN);   // just above range
      send_frame(FR_GOOD, 8'd32, 8'd200, FRAME_LEN);    // just below range
      send_frame(FR_GOOD, 8'd0, 8'd0, FRAME_LEN);
      send_frame(FR_GOOD, 8'd225, 8'd230, FRAME_LEN);   // falls between two table entries
      send_frame(FR_GOOD, 8'd128, 8'd127, FRAME_LEN);   // second reading is the lesser
      send_frame(FR_BAD_HDR, 8'd100, 8'd100, FRAME_LEN);
      send_frame(FR_BAD_SUM, 8'd250, 8'd250, FRAME_LEN); // checksum wins over range
      // truncated frame, then resync on a fresh one
      send_frame(FR_GOOD, 8'd40, 8'd35, 12);
      send_frame(FR_GOOD, 8'd60, 8'd61, FRAME_LEN);
      // sync byte in the last slot restarts instead of completing
      send_frame(FR_GOOD, 8'd70, 8'd70, FRAME_LEN - 1);
      send_byte(esc_temp_pkg::SYNC_BYTE);
      send_frame(FR_GOOD, 8'd90, 8'd95, FRAME_LEN);

      // random: mostly well-formed frames, some broken ones and raw noise
      while (bytes_sent < BYTE_TARGET) begin
         if (bytes_sent >= BYTE_TARGET - CALM_BYTES) calm_tail = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 70)
            send_frame(FR_GOOD, pick_reading(), pick_reading(), FRAME_LEN);
         else if (pick < 80)
            send_frame(FR_BAD_SUM, pick_reading(), pick_reading(), FRAME_LEN);
         else if (pick < 85)
            send_frame(FR_BAD_HDR, pick_reading(), pick_reading(), FRAME_LEN);
         else if (pick < 92)
            send_frame(FR_GOOD, pick_reading(), pick_reading(), $urandom_range(1, FRAME_LEN - 1));
         else
            repeat ($urandom_range(1, 30)) send_byte(8'($urandom_range(0, 255)));
      end
      req_tvalid <= 1'b0;

      // drain outstanding verdicts, then give the search loop time to misbehave
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("run: %0d bytes in, %0d frames judged, %0d mismatches",
               bytes_sent, board.frames_judged, board.errors);
      $display("verdicts: ok %0d, bad header %0d, bad checksum %0d, high %0d, low %0d",
               board.status_seen[esc_temp_pkg::ST_OK], board.status_seen[esc_temp_pkg::ST_BAD_HDR],
               board.status_seen[esc_temp_pkg::ST_BAD_SUM], board.status_seen[esc_temp_pkg::ST_HIGH],
               board.status_seen[esc_temp_pkg::ST_LOW]);
      if (board.errors == 0 && board.awaited.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

### sim.f
rtl/esc_temp_pkg.sv
rtl/esc_temp_ctrl.sv
rtl/esc_temp_dp.sv
rtl/esc_telemetry_frame_temperature.sv
tb/testbench.sv
